FILE: src/rfcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rfcd_pkg;

    localparam int MAX_FIELDS_DEF   = 32;
    localparam int REPORT_BYTES_DEF = 64;
    localparam int EVENT_CAP        = 32;
    localparam int LEN_W            = 7;
    localparam int POS_W            = 9;
    localparam int SIZE_W           = 6;
    localparam int ID_W             = 16;
    localparam int VAL_W            = 32;
    localparam int IDX_W            = 5;
    localparam int ENTRY_W          = 32;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_DEFINE = 2'd1;
    localparam logic [1:0] CMD_BYTE   = 2'd2;

    localparam logic CFG_BYTE_ORDER   = 1'b0;
    localparam logic CFG_REPORT_BYTES = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_DEFINE,
        OP_BYTE
    } t_op_kind;

    // one classified beat handed from front to back
    typedef struct packed {
        t_op_kind          kind;
        logic [POS_W-1:0]  pos;
        logic [SIZE_W-1:0] size;
        logic              sgn;
        logic [ID_W-1:0]   id;
        logic [7:0]        data;
        logic              last;
    } t_op;

    // table entry: position [8:0], size [14:9], signed [15], id [31:16]
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              sgn;
        logic [SIZE_W-1:0] size;
        logic [POS_W-1:0]  pos;
    } t_entry;

    // turn a 32-bit stream window into the field value
    function automatic logic [VAL_W-1:0] field_value(
        input logic [VAL_W-1:0]  win,
        input logic [SIZE_W-1:0] size,
        input logic              sgn,
        input logic              big
    );
        logic [VAL_W-1:0] rev;
        logic [VAL_W-1:0] mask;
        logic [VAL_W-1:0] v;
        logic [5:0]       sh;
        for (int k = 0; k < VAL_W; k++) begin
            rev[k] = win[VAL_W-1-k];
        end
        sh   = 6'd32 - size;
        mask = (size >= 6'd32) ? '1 : ((VAL_W'(1) << size[4:0]) - VAL_W'(1));
        if (big) begin
            v = rev >> sh[4:0];
        end else begin
            v = win & mask;
        end
        if (sgn && size < 6'd32 && size != 6'd0 && v[size[4:0] - 5'd1]) begin
            v = v | ~mask;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: src/rfcd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rfcd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [8:0]  field_position;
    logic [5:0]  field_size;
    logic        field_signed;
    logic [15:0] field_id;
    logic [7:0]  data_byte;
    logic        last_byte;

    modport source (output valid, cmd, field_position, field_size, field_signed,
                    field_id, data_byte, last_byte, input ready);
    modport sink (input valid, cmd, field_position, field_size, field_signed,
                  field_id, data_byte, last_byte, output ready);
endinterface
`default_nettype wire

FILE: src/rfcd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rfcd_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_index;
    logic [15:0] event_id;
    logic [31:0] new_value;
    logic [31:0] old_value;
    logic        last_event;

    modport source (output valid, field_index, event_id, new_value, old_value,
                    last_event, input ready);
    modport sink (input valid, field_index, event_id, new_value, old_value,
                  last_event, output ready);
endinterface
`default_nettype wire

FILE: src/rfcd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rfcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/rfcd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rfcd_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rfcd_in_if.sink          i_in_ch,
    input  wire logic        i_q_ready,
    output logic             o_q_push,
    output rfcd_pkg::t_op    o_q_op
);
    import rfcd_pkg::*;

    assign i_in_ch.ready = i_q_ready;

    // classify the beat; unused codes and bad sizes go nowhere
    always_comb begin
        o_q_op.pos  = i_in_ch.field_position;
        o_q_op.size = i_in_ch.field_size;
        o_q_op.sgn  = i_in_ch.field_signed;
        o_q_op.id   = i_in_ch.field_id;
        o_q_op.data = i_in_ch.data_byte;
        o_q_op.last = i_in_ch.last_byte;
        o_q_op.kind = OP_CLEAR;
        o_q_push    = 1'b0;
        unique case (i_in_ch.cmd)
            CMD_CLEAR: begin
                o_q_push = i_in_ch.valid;
            end
            CMD_DEFINE: begin
                o_q_op.kind = OP_DEFINE;
                o_q_push    = i_in_ch.valid && i_in_ch.field_size != 6'd0
                              && i_in_ch.field_size <= 6'd32;
            end
            CMD_BYTE: begin
                o_q_op.kind = OP_BYTE;
                o_q_push    = i_in_ch.valid;
            end
            default: begin
                o_q_push = 1'b0;
            end
        endcase
        o_q_push = o_q_push && i_q_ready;
    end
endmodule
`default_nettype wire

FILE: src/rfcd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rfcd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  rfcd_pkg::t_op      i_op,
    output logic               o_ready,
    output logic               o_valid,
    output rfcd_pkg::t_op      o_op,
    input  wire logic          i_pop
);
    import rfcd_pkg::*;

    t_op        r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

    // two-entry ring with a fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

FILE: src/rfcd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rfcd_back #(
    parameter int MAX_FIELDS   = rfcd_pkg::MAX_FIELDS_DEF,
    parameter int REPORT_BYTES = rfcd_pkg::REPORT_BYTES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_byte_order,
    input  wire logic [rfcd_pkg::LEN_W-1:0] i_report_bytes,
    input  wire logic                   i_q_valid,
    input  rfcd_pkg::t_op               i_q_op,
    output logic                        o_q_pop,
    rfcd_out_if.source                  o_out_ch
);
    import rfcd_pkg::*;

    localparam int FC_W      = $clog2(MAX_FIELDS + 1);
    localparam int AW        = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int EC_W      = $clog2(EVENT_CAP + 1);
    localparam int RA_W      = (REPORT_BYTES > 1) ? $clog2(REPORT_BYTES) : 1;
    localparam int BA_W      = POS_W - 2;
    localparam int WIN_BYTES = 5;
    localparam int WIN_W     = WIN_BYTES * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EXT,
        S_FETCH,
        S_CMP,
        S_FIN
    } t_state;

    t_state              r_state;
    logic                r_bank;
    logic [REPORT_BYTES-1:0] r_flg0;
    logic [REPORT_BYTES-1:0] r_flg1;
    logic [REPORT_BYTES-1:0] n_flg0;
    logic [REPORT_BYTES-1:0] n_flg1;
    logic [FC_W-1:0]     r_fcnt;
    logic [LEN_W-1:0]    r_bcnt;
    logic [FC_W-1:0]     r_idx;
    logic [EC_W-1:0]     r_ecnt;
    logic [LEN_W-1:0]    eff;
    logic                def_ok;
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_q;
    t_entry              q_ent;
    t_entry              r_ent;
    logic                r_skip;
    logic [2:0]          r_k;
    logic [BA_W-1:0]     ba;
    logic                ba_in;
    logic [RA_W-1:0]     rep_addr;
    logic                byte_we;
    logic                wr_bank;
    logic                rep_we0;
    logic                rep_we1;
    logic [7:0]          rep_q0;
    logic [7:0]          rep_q1;
    logic [7:0]          cur_q;
    logic [7:0]          prev_q;
    logic                cur_flg;
    logic                prev_flg;
    logic                r_cur_ok;
    logic                r_prev_ok;
    logic [7:0]          cur_byte;
    logic [7:0]          prev_byte;
    logic [WIN_W-1:0]    r_wn;
    logic [WIN_W-1:0]    r_wp;
    logic [VAL_W-1:0]    nv;
    logic [VAL_W-1:0]    pv;
    logic                out_free;
    logic                o_load;
    logic                r_pend;
    logic [FC_W-1:0]     r_p_idx;
    logic [ID_W-1:0]     r_p_id;
    logic [VAL_W-1:0]    r_p_new;
    logic [VAL_W-1:0]    r_p_old;
    logic                r_o_valid;
    logic [FC_W-1:0]     r_o_idx;
    logic [ID_W-1:0]     r_o_id;
    logic [VAL_W-1:0]    r_o_new;
    logic [VAL_W-1:0]    r_o_old;
    logic                r_o_last;

    // effective report length, clamped to 1..REPORT_BYTES
    always_comb begin
        if (i_report_bytes == '0) begin
            eff = LEN_W'(1);
        end else if (32'(i_report_bytes) > REPORT_BYTES) begin
            eff = LEN_W'(REPORT_BYTES);
        end else begin
            eff = i_report_bytes;
        end
    end

    // a definition must end inside the report and find a free slot
    assign def_ok = (11'(i_q_op.pos) + 11'(i_q_op.size) <= {1'b0, eff, 3'b000})
                    && (32'(r_fcnt) < MAX_FIELDS);
    assign ram_we = (r_state == S_IDLE) && i_q_valid && i_q_op.kind == OP_DEFINE && def_ok;

    rfcd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_FIELDS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fcnt[AW-1:0]),
        .i_wdata ({i_q_op.id, i_q_op.sgn, i_q_op.size, i_q_op.pos}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_q)
    );
    assign q_ent = t_entry'(ram_q);

    // two report banks swap roles at the start of each report
    assign byte_we = o_q_pop && i_q_op.kind == OP_BYTE && (r_bcnt < eff);
    assign wr_bank = (r_bcnt == '0) ? ~r_bank : r_bank;
    assign rep_we0 = byte_we && !wr_bank;
    assign rep_we1 = byte_we && wr_bank;

    // report byte address for the field window
    assign ba       = BA_W'(r_ent.pos[POS_W-1:3]) + BA_W'(r_k);
    assign ba_in    = (32'(ba) < REPORT_BYTES);
    assign rep_addr = ba[RA_W-1:0];

    rfcd_ram #(.WIDTH(8), .DEPTH(REPORT_BYTES)) u_rep0 (
        .i_clk   (i_clk),
        .i_we    (rep_we0),
        .i_waddr (r_bcnt[RA_W-1:0]),
        .i_wdata (i_q_op.data),
        .i_raddr (rep_addr),
        .o_rdata (rep_q0)
    );

    rfcd_ram #(.WIDTH(8), .DEPTH(REPORT_BYTES)) u_rep1 (
        .i_clk   (i_clk),
        .i_we    (rep_we1),
        .i_waddr (r_bcnt[RA_W-1:0]),
        .i_wdata (i_q_op.data),
        .i_raddr (rep_addr),
        .o_rdata (rep_q1)
    );

    assign cur_q    = r_bank ? rep_q1 : rep_q0;
    assign prev_q   = r_bank ? rep_q0 : rep_q1;
    assign cur_flg  = r_bank ? r_flg1[rep_addr] : r_flg0[rep_addr];
    assign prev_flg = r_bank ? r_flg0[rep_addr] : r_flg1[rep_addr];

    // unwritten bytes read as zero; msb-first order reverses each byte
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            cur_byte[k]  = r_cur_ok && (i_byte_order ? cur_q[7-k] : cur_q[k]);
            prev_byte[k] = r_prev_ok && (i_byte_order ? prev_q[7-k] : prev_q[k]);
        end
    end

    // written-byte flags for both banks
    always_comb begin
        n_flg0 = r_flg0;
        n_flg1 = r_flg1;
        if (o_q_pop && i_q_op.kind == OP_CLEAR) begin
            n_flg0 = '0;
            n_flg1 = '0;
        end else if (o_q_pop && i_q_op.kind == OP_BYTE) begin
            if (r_bcnt == '0) begin
                if (wr_bank) begin
                    n_flg1 = '0;
                end else begin
                    n_flg0 = '0;
                end
            end
            if (byte_we) begin
                if (wr_bank) begin
                    n_flg1[r_bcnt[RA_W-1:0]] = 1'b1;
                end else begin
                    n_flg0[r_bcnt[RA_W-1:0]] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_flg0 <= '0;
            r_flg1 <= '0;
        end else begin
            r_flg0 <= n_flg0;
            r_flg1 <= n_flg1;
            if (o_q_pop && i_q_op.kind == OP_BYTE && r_bcnt == '0) begin
                r_bank <= ~r_bank;
            end
        end
    end

    assign nv       = field_value(VAL_W'(r_wn >> r_ent.pos[2:0]), r_ent.size, r_ent.sgn,
                                  i_byte_order);
    assign pv       = field_value(VAL_W'(r_wp >> r_ent.pos[2:0]), r_ent.size, r_ent.sgn,
                                  i_byte_order);
    assign out_free = !r_o_valid || o_out_ch.ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_load   = r_pend && out_free
                      && ((r_state == S_CMP && !(r_skip || nv == pv)
                           && !(32'(r_ecnt) >= EVENT_CAP))
                          || r_state == S_FIN);

    assign o_out_ch.valid       = r_o_valid;
    assign o_out_ch.field_index = r_o_idx[IDX_W-1:0];
    assign o_out_ch.event_id    = r_o_id;
    assign o_out_ch.new_value   = r_o_new;
    assign o_out_ch.old_value   = r_o_old;
    assign o_out_ch.last_event  = r_o_last;

    // walk payload: latch the entry, then gather five report bytes
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXT) begin
            r_ent  <= q_ent;
            r_skip <= (q_ent.size == 6'd1) && (q_ent.id == '0);
            r_k    <= 3'd0;
        end
        if (r_state == S_FETCH) begin
            r_k       <= r_k + 3'd1;
            r_cur_ok  <= ba_in && cur_flg;
            r_prev_ok <= ba_in && prev_flg;
            if (r_k != 3'd0) begin
                r_wn <= {cur_byte, r_wn[WIN_W-1:8]};
                r_wp <= {prev_byte, r_wp[WIN_W-1:8]};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= 1'b1;
            r_o_idx   <= r_p_idx;
            r_o_id    <= r_p_id;
            r_o_new   <= r_p_new;
            r_o_old   <= r_p_old;
            r_o_last  <= (r_state == S_FIN);
        end else if (r_o_valid && o_out_ch.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // sequencer: executes ops, then walks the table and holds back one event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fcnt  <= '0;
            r_bcnt  <= '0;
            r_idx   <= '0;
            r_ecnt  <= '0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        unique case (i_q_op.kind)
                            OP_CLEAR: begin
                                r_fcnt <= '0;
                                r_bcnt <= '0;
                            end
                            OP_DEFINE: begin
                                if (def_ok) begin
                                    r_fcnt <= r_fcnt + FC_W'(1);
                                end
                            end
                            OP_BYTE: begin
                                if (r_bcnt < eff) begin
                                    r_bcnt <= r_bcnt + LEN_W'(1);
                                end
                                if (i_q_op.last) begin
                                    r_bcnt <= '0;
                                    r_idx  <= '0;
                                    r_ecnt <= '0;
                                    r_pend <= 1'b0;
                                    if (r_fcnt != '0) begin
                                        r_state <= S_RD;
                                    end
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_EXT;
                end
                S_EXT: begin
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    if (r_k == 3'(WIN_BYTES)) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_skip || nv == pv) begin
                        r_idx   <= r_idx + FC_W'(1);
                        r_state <= (r_idx + FC_W'(1) == r_fcnt) ? S_FIN : S_RD;
                    end else if (32'(r_ecnt) >= EVENT_CAP) begin
                        r_state <= S_FIN;
                    end else if (!r_pend || out_free) begin
                        r_pend  <= 1'b1;
                        r_p_idx <= r_idx;
                        r_p_id  <= r_ent.id;
                        r_p_new <= nv;
                        r_p_old <= pv;
                        r_ecnt  <= r_ecnt + EC_W'(1);
                        r_idx   <= r_idx + FC_W'(1);
                        r_state <= (r_idx + FC_W'(1) == r_fcnt) ? S_FIN : S_RD;
                    end
                end
                S_FIN: begin
                    if (!r_pend) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/report_field_change_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Report field change detector. Beats on the input channel clear the field
// table, define a field, or deliver one report byte. The back end executes
// clear, define and plain byte beats from a two-entry queue while idle. The
// byte marked last starts a walk over the field table if any field is
// defined: each field goes through a table memory read, an entry latch, the
// reading of five report bytes from both report memories, a compare and a
// hand-off. The back end stays busy with that beat through the walk, also
// while the output side stalls. Change events come out in definition order
// through one output register; the last one of a report carries last_event.
// Configuration is written through i_cfg_we, i_cfg_idx, i_cfg_data.
module report_field_change_detector_unit #(
    parameter int MAX_FIELDS   = rfcd_pkg::MAX_FIELDS_DEF,
    parameter int REPORT_BYTES = rfcd_pkg::REPORT_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    rfcd_in_if.sink                         i_in_ch,
    rfcd_out_if.source                      o_out_ch,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [rfcd_pkg::LEN_W-1:0] i_cfg_data
);
    import rfcd_pkg::*;

    logic             r_byte_order;
    logic [LEN_W-1:0] r_report_bytes;
    logic             q_ready;
    logic             q_push;
    t_op              q_in;
    logic             q_valid;
    t_op              q_out;
    logic             q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order   <= 1'b0;
            r_report_bytes <= LEN_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BYTE_ORDER:   r_byte_order   <= i_cfg_data[0];
                CFG_REPORT_BYTES: r_report_bytes <= i_cfg_data;
                default:          r_byte_order   <= r_byte_order;
            endcase
        end
    end

    rfcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_ch   (i_in_ch),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_op    (q_in)
    );

    rfcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_out),
        .i_pop   (q_pop)
    );

    rfcd_back #(.MAX_FIELDS(MAX_FIELDS), .REPORT_BYTES(REPORT_BYTES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_order   (r_byte_order),
        .i_report_bytes (r_report_bytes),
        .i_q_valid      (q_valid),
        .i_q_op         (q_out),
        .o_q_pop        (q_pop),
        .o_out_ch       (o_out_ch)
    );
endmodule
`default_nettype wire
